>>> sv/hvs_pkg.sv
`default_nettype none
package hvs_pkg;

    localparam int BYTES_PER_LINE_DEF = 64;
    localparam int BILEVEL_LINES_DEF  = 240;
    localparam int GRADIENT_LINES_DEF = 120;

    localparam int QUEUE_DEPTH = 2;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam logic        MODE_RESET  = 1'b1;
    localparam logic [15:0] BASE_RESET  = 16'hE000;
    localparam logic [7:0]  RED_RESET   = 8'd0;
    localparam logic [7:0]  GREEN_RESET = 8'd255;
    localparam logic [7:0]  BLUE_RESET  = 8'd0;

    localparam logic [3:0]  LEVEL_FULL  = 4'hF;
    localparam logic [12:0] DIV15_RECIP = 13'd4370;

    typedef enum logic [2:0] {
        REG_MODE  = 3'd0,
        REG_BASE  = 3'd1,
        REG_RED   = 3'd2,
        REG_GREEN = 3'd3,
        REG_BLUE  = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic        video_mode;
        logic [15:0] base_address;
        logic [7:0]  fg_red;
        logic [7:0]  fg_green;
        logic [7:0]  fg_blue;
    } cfg_t;

    typedef struct packed {
        logic [15:0] source_address;
        logic [7:0]  line;
        logic [7:0]  pos;
        logic [7:0]  video_byte;
        logic        bilevel;
        logic        subrow;
        logic        frame_end;
    } desc_t;

    // The even subrow uses bits 7, 6, 3, 2 and the odd subrow bits 5, 4, 1, 0.
    function automatic logic [2:0] bit_select(input logic subrow, input logic [1:0] k);
        return {~k[1], ~subrow, ~k[0]};
    endfunction

    // Exact floor(x / 15) for x up to 15 * 255.
    function automatic logic [7:0] grade_div15(input logic [11:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'(DIV15_RECIP);
        return p[23:16];
    endfunction

endpackage
`default_nettype wire

>>> sv/hvs_regs.sv
`default_nettype none
module hvs_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [hvs_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [hvs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [hvs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output hvs_pkg::cfg_t                          cfg
);
    import hvs_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = reg_index_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        prdata   = '0;
        unique case (index)
            REG_MODE: begin
                prdata = APB_DATA_W'(cfg_reg.video_mode);
                if (wr_en) cfg_next.video_mode = pwdata[0];
            end
            REG_BASE: begin
                prdata = APB_DATA_W'(cfg_reg.base_address);
                if (wr_en) cfg_next.base_address = pwdata[15:0];
            end
            REG_RED: begin
                prdata = APB_DATA_W'(cfg_reg.fg_red);
                if (wr_en) cfg_next.fg_red = pwdata[7:0];
            end
            REG_GREEN: begin
                prdata = APB_DATA_W'(cfg_reg.fg_green);
                if (wr_en) cfg_next.fg_green = pwdata[7:0];
            end
            REG_BLUE: begin
                prdata = APB_DATA_W'(cfg_reg.fg_blue);
                if (wr_en) cfg_next.fg_blue = pwdata[7:0];
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.video_mode   <= MODE_RESET;
            cfg_reg.base_address <= BASE_RESET;
            cfg_reg.fg_red       <= RED_RESET;
            cfg_reg.fg_green     <= GREEN_RESET;
            cfg_reg.fg_blue      <= BLUE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/hvs_front.sv
`default_nettype none
module hvs_front #(
    parameter int BYTES_PER_LINE = hvs_pkg::BYTES_PER_LINE_DEF,
    parameter int BILEVEL_LINES  = hvs_pkg::BILEVEL_LINES_DEF,
    parameter int GRADIENT_LINES = hvs_pkg::GRADIENT_LINES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          s_tuser,
    input  hvs_pkg::cfg_t      cfg,
    input  wire logic          q_full,
    output logic               q_push,
    output hvs_pkg::desc_t     q_data
);
    import hvs_pkg::*;

    localparam int MAX_LINES = (BILEVEL_LINES > GRADIENT_LINES) ? BILEVEL_LINES
                                                                : GRADIENT_LINES;
    localparam int POS_W  = $clog2(BYTES_PER_LINE + 1);
    localparam int LINE_W = $clog2(MAX_LINES + 1);

    logic [POS_W-1:0]  pos_reg, pos_next, pos_eff;
    logic [LINE_W-1:0] line_reg, line_next, line_eff;
    logic              subrow_reg, subrow_next, subrow_eff;
    logic [15:0]       block_reg, block_next, block_eff;

    logic        bilevel, line_end, frame_end;
    logic [31:0] lines, line_ext, pos_ext;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;
    assign bilevel  = !cfg.video_mode;

    always_comb begin
        if (s_tuser) begin
            pos_eff    = '0;
            line_eff   = '0;
            subrow_eff = 1'b0;
            block_eff  = cfg.base_address;
        end else begin
            pos_eff    = pos_reg;
            line_eff   = line_reg;
            subrow_eff = subrow_reg;
            block_eff  = block_reg;
        end

        lines     = bilevel ? 32'(BILEVEL_LINES) : 32'(GRADIENT_LINES);
        line_ext  = 32'(line_eff);
        pos_ext   = 32'(pos_eff);
        line_end  = (pos_ext + 32'd1) >= 32'(BYTES_PER_LINE);
        frame_end = line_end && ((line_ext + 32'd1) >= lines);

        q_data.source_address = block_eff + 16'(pos_eff);
        q_data.line           = line_ext[7:0];
        q_data.pos            = pos_ext[7:0];
        q_data.video_byte     = s_tdata;
        q_data.bilevel        = bilevel;
        q_data.subrow         = subrow_eff;
        q_data.frame_end      = frame_end;

        pos_next    = pos_eff;
        line_next   = line_eff;
        subrow_next = subrow_eff;
        block_next  = block_eff;
        if (!line_end) begin
            pos_next = POS_W'(pos_eff + 1'b1);
        end else begin
            pos_next = '0;
            if (bilevel && !subrow_eff) begin
                subrow_next = 1'b1;
            end else begin
                subrow_next = 1'b0;
                block_next  = block_eff + 16'(BYTES_PER_LINE);
            end
            if (frame_end) begin
                line_next   = '0;
                subrow_next = 1'b0;
                block_next  = cfg.base_address;
            end else begin
                line_next = LINE_W'(line_eff + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            line_reg   <= '0;
            subrow_reg <= 1'b0;
            block_reg  <= BASE_RESET;
        end else if (q_push) begin
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            subrow_reg <= subrow_next;
            block_reg  <= block_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/hvs_queue.sv
`default_nettype none
module hvs_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  hvs_pkg::desc_t     push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               out_valid,
    output hvs_pkg::desc_t     out_data
);
    import hvs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                               : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                               : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> out_valid) else $error("queue read while empty");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("queue count did not follow a write");

endmodule
`default_nettype wire

>>> sv/hvs_back.sv
`default_nettype none
module hvs_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  hvs_pkg::cfg_t      cfg,
    input  wire logic          q_valid,
    input  hvs_pkg::desc_t     q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [55:0]        m_tdata,
    output logic               m_tlast,
    output logic               m_tuser
);
    import hvs_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic        adv, last_pix;
    logic [3:0]  level;
    logic [7:0]  column;

    logic        s1_valid_reg;
    logic [11:0] s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [15:0] s1_addr_reg;
    logic [7:0]  s1_col_reg, s1_line_reg;
    logic        s1_last_reg, s1_fend_reg;

    logic        m_valid_reg;
    logic [55:0] m_data_reg;
    logic        m_last_reg, m_fend_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign last_pix = q_data.bilevel ? (idx_reg == 2'd3) : (idx_reg == 2'd1);
    assign q_pop    = adv && q_valid && last_pix;

    always_comb begin
        if (q_data.bilevel) begin
            level  = q_data.video_byte[bit_select(q_data.subrow, idx_reg)] ? LEVEL_FULL
                                                                           : 4'h0;
            column = 8'({q_data.pos, 2'b00}) + 8'(idx_reg);
        end else begin
            level  = idx_reg[0] ? q_data.video_byte[3:0] : q_data.video_byte[7:4];
            column = 8'({q_data.pos, 1'b0}) + 8'(idx_reg);
        end
        idx_next = idx_reg;
        if (adv && q_valid) begin
            idx_next = last_pix ? 2'd0 : 2'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_red_reg   <= 12'(level) * 12'(cfg.fg_red);
            s1_green_reg <= 12'(level) * 12'(cfg.fg_green);
            s1_blue_reg  <= 12'(level) * 12'(cfg.fg_blue);
            s1_addr_reg  <= q_data.source_address;
            s1_col_reg   <= column;
            s1_line_reg  <= q_data.line;
            s1_last_reg  <= last_pix;
            s1_fend_reg  <= last_pix && q_data.frame_end;
            m_data_reg   <= {grade_div15(s1_blue_reg), grade_div15(s1_green_reg),
                             grade_div15(s1_red_reg), s1_line_reg, s1_col_reg,
                             s1_addr_reg};
            m_last_reg   <= s1_last_reg;
            m_fend_reg   <= s1_fend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= 2'd0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (adv) begin
                s1_valid_reg <= q_valid;
                m_valid_reg  <= s1_valid_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_fend_reg;

    a_gradient_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !q_data.bilevel) |-> !idx_reg[1])
        else $error("gradient byte sequenced past its second pixel");
    a_fend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_fend_reg) |-> m_last_reg)
        else $error("frame end flagged on a pixel that does not end its byte");
    a_idx_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!adv || !q_valid) |=> $stable(idx_reg))
        else $error("pixel index moved without a transfer into the pipeline");

endmodule
`default_nettype wire

>>> sv/hires_video_scanout_unit.sv
// Channel   Direction  Transfer    Contents
// s_        in         byte        tdata = video_byte, tuser = frame_restart
// m_        out        pixel       tdata = address, column, line, RGB; tlast, tuser
// APB       in         register    video_mode, base_address, fg_red, fg_green, fg_blue
//
// A byte yields four pixels in bilevel mode and two in gradient mode, one per cycle unless the output stalls.
// The pixel sequencer in the back end sets the rate: it pops a byte only with that byte's last pixel.
// A pixel passes from its byte transfer through the queue entry, the s1 registers and the output register.
// Reset is synchronous; counters clear and the registers take their reset values.
// A two-entry queue and the output register let either side stall independently.
`default_nettype none
module hires_video_scanout_unit #(
    parameter int BYTES_PER_LINE = hvs_pkg::BYTES_PER_LINE_DEF,
    parameter int BILEVEL_LINES  = hvs_pkg::BILEVEL_LINES_DEF,
    parameter int GRADIENT_LINES = hvs_pkg::GRADIENT_LINES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // video_byte
    input  wire logic [7:0]                        s_tdata,
    // frame_restart
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // source_address, pixel_column, pixel_line, red_out, green_out, blue_out
    output logic [55:0]                            m_tdata,
    output logic                                   m_tlast,
    // frame_end
    output logic                                   m_tuser,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [hvs_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [hvs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [hvs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready
);
    import hvs_pkg::*;

    cfg_t  cfg;
    desc_t push_data, head_data;
    logic  q_full, q_push, q_pop, q_valid;

    hvs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hvs_front #(
        .BYTES_PER_LINE (BYTES_PER_LINE),
        .BILEVEL_LINES  (BILEVEL_LINES),
        .GRADIENT_LINES (GRADIENT_LINES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    hvs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_data  (head_data)
    );

    hvs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_data   (head_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import hvs_pkg::*;

    localparam int BYTES_PER_LINE = BYTES_PER_LINE_DEF;
    localparam int BILEVEL_LINES  = BILEVEL_LINES_DEF;
    localparam int GRADIENT_LINES = GRADIENT_LINES_DEF;
    localparam int unsigned REG_SPARE_FIRST = REG_BLUE + 1;
    localparam int unsigned REG_SPARE_LAST  = (2 ** APB_ADDR_W) / 4 - 1;
    localparam logic [31:0] EVEN_SUBROW_MASKS = 32'h0408_4080;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  column;
        logic [7:0]  line;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last;
        logic        frame_done;
    } pixel_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [55:0]           m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic        mode_reg  = MODE_RESET;
    logic [15:0] base_reg  = BASE_RESET;
    logic [7:0]  red_reg   = RED_RESET;
    logic [7:0]  green_reg = GREEN_RESET;
    logic [7:0]  blue_reg  = BLUE_RESET;

    int unsigned line_cnt = 0;
    int unsigned byte_pos = 0;
    logic        odd_subrow = 1'b0;
    logic [15:0] block_addr = BASE_RESET;

    pixel_t pending_pixels[$];
    int     mismatches = 0;
    int     idle_max = 11;
    int     ready_hold = 0;

    hires_video_scanout_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t ns %s: expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    function automatic logic [31:0] shadow_value(input int unsigned idx);
        case (idx)
            REG_MODE:  return 32'(mode_reg);
            REG_BASE:  return 32'(base_reg);
            REG_RED:   return 32'(red_reg);
            REG_GREEN: return 32'(green_reg);
            REG_BLUE:  return 32'(blue_reg);
            default:   return '0;
        endcase
    endfunction

    function automatic void predict_pixels(input logic [7:0] vbyte, input logic restart);
        pixel_t      px;
        logic        bilevel;
        int unsigned lines;
        int unsigned count;
        int unsigned level;
        logic [7:0]  mask;
        logic        line_end;
        logic        frame_done;

        bilevel = (mode_reg == 1'b0);
        lines = bilevel ? BILEVEL_LINES : GRADIENT_LINES;
        count = bilevel ? 4 : 2;
        if (restart) begin
            line_cnt = 0;
            byte_pos = 0;
            odd_subrow = 1'b0;
            block_addr = base_reg;
        end
        line_end = (byte_pos + 1 >= BYTES_PER_LINE);
        frame_done = line_end && (line_cnt + 1 >= lines);
        for (int k = 0; k < count; k++) begin
            px.addr = block_addr + 16'(byte_pos);
            px.column = 8'(byte_pos * count + k);
            px.line = 8'(line_cnt);
            if (bilevel) begin
                mask = EVEN_SUBROW_MASKS[8*k +: 8] >> (odd_subrow ? 2 : 0);
                level = ((vbyte & mask) != 0) ? LEVEL_FULL : 0;
            end else begin
                level = (k == 0) ? vbyte[7:4] : vbyte[3:0];
            end
            px.red = 8'((level * red_reg) / LEVEL_FULL);
            px.green = 8'((level * green_reg) / LEVEL_FULL);
            px.blue = 8'((level * blue_reg) / LEVEL_FULL);
            px.last = (k == count - 1);
            px.frame_done = px.last && frame_done;
            pending_pixels.push_back(px);
        end
        if (!line_end) begin
            byte_pos++;
        end else begin
            byte_pos = 0;
            if (!bilevel || odd_subrow) begin
                block_addr = block_addr + 16'(BYTES_PER_LINE);
                odd_subrow = 1'b0;
            end else begin
                odd_subrow = 1'b1;
            end
            if (frame_done) begin
                line_cnt = 0;
                odd_subrow = 1'b0;
                block_addr = base_reg;
            end else begin
                line_cnt++;
            end
        end
    endfunction

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_tready <= 1'b0;
            ready_hold--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : pixel_check
        pixel_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                $display("%0t ns unexpected pixel: expected none, actual %h/%b/%b",
                         $time, m_tdata, m_tlast, m_tuser);
            end else begin
                want = pending_pixels.pop_front();
                check_field("source_address", want.addr, m_tdata[15:0]);
                check_field("pixel_column", want.column, m_tdata[23:16]);
                check_field("pixel_line", want.line, m_tdata[31:24]);
                check_field("red_out", want.red, m_tdata[39:32]);
                check_field("green_out", want.green, m_tdata[47:40]);
                check_field("blue_out", want.blue, m_tdata[55:48]);
                check_field("last_of_byte", want.last, m_tlast);
                check_field("frame_end", want.frame_done, m_tuser);
            end
            ready_hold = $urandom_range(0, idle_max);
        end
    end

    task automatic send_byte(input logic [7:0] vbyte, input logic restart);
        int gap;
        gap = $urandom_range(0, idle_max);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= vbyte;
        s_tuser <= restart;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_pixels(vbyte, restart);
    endtask

    task automatic wait_pixels_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input int unsigned idx, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(idx * 4);
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        case (idx)
            REG_MODE:  mode_reg = value[0];
            REG_BASE:  base_reg = value[15:0];
            REG_RED:   red_reg = value[7:0];
            REG_GREEN: green_reg = value[7:0];
            REG_BLUE:  blue_reg = value[7:0];
            default:   ;
        endcase
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read_check(input int unsigned idx);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= APB_ADDR_W'(idx * 4);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        check_field($sformatf("prdata of register %0d", idx), shadow_value(idx), prdata);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic mode, input logic [15:0] base,
                              input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
        apb_write(REG_MODE, 32'(mode));
        apb_write(REG_BASE, 32'(base));
        apb_write(REG_RED, 32'(red));
        apb_write(REG_GREEN, 32'(green));
        apb_write(REG_BLUE, 32'(blue));
    endtask

    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_register_access();
        for (int unsigned i = REG_MODE; i <= REG_BLUE; i++) apb_read_check(i);
        set_config(1'b0, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        for (int unsigned i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++) begin
            apb_write(i, $urandom);
        end
        for (int unsigned i = REG_MODE; i <= REG_BLUE; i++) apb_read_check(i);
        set_config(1'b1, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        for (int unsigned i = REG_MODE; i <= REG_BLUE; i++) apb_read_check(i);
    endtask

    task automatic test_directed_patterns();
        logic [7:0] gradient_bytes[8] = '{8'h00, 8'hFF, 8'hF0, 8'h0F, 8'h12, 8'h87,
                                          8'h11, 8'h7E};
        logic [7:0] bilevel_bytes[10] = '{8'h80, 8'h40, 8'h08, 8'h04, 8'h20, 8'h10,
                                          8'h02, 8'h01, 8'hFF, 8'h00};
        set_config(1'b1, BASE_RESET, 8'hFF, 8'hFF, 8'hFF);
        foreach (gradient_bytes[i]) send_byte(gradient_bytes[i], i == 0);
        wait_pixels_drained();
        set_config(1'b1, 16'hFFFF, 8'h80, 8'h01, 8'hFE);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hE1, 1'b0);
        wait_pixels_drained();
        set_config(1'b0, 16'h0000, 8'hFF, 8'h00, 8'h80);
        foreach (bilevel_bytes[i]) send_byte(bilevel_bytes[i], i == 2);
        wait_pixels_drained();
    endtask

    task automatic test_random_traffic();
        logic        mode;
        logic [15:0] base;
        for (int phase = 0; phase < 8; phase++) begin
            mode = (phase < 4) ? phase[0] : 1'($urandom);
            case (phase)
                0:       base = 16'h0000;
                1:       base = 16'hFFFF;
                default: base = 16'($urandom);
            endcase
            if (phase == 0) begin
                set_config(mode, base, 8'h00, 8'h00, 8'h00);
            end else if (phase == 1) begin
                set_config(mode, base, 8'hFF, 8'hFF, 8'hFF);
            end else begin
                set_config(mode, base, random_level(), random_level(), random_level());
            end
            idle_max = (phase % 4 == 3) ? 0 : 11;
            for (int i = 0; i < 24; i++) begin
                send_byte(8'($urandom),
                          (i == 0) ? 1'($urandom) : ($urandom_range(0, 63) == 0));
            end
            wait_pixels_drained();
        end
        idle_max = 11;
    endtask

    task automatic test_line_boundaries();
        idle_max = 0;
        set_config(1'b0, 16'hFFC0, 8'hFF, 8'h80, 8'h01);
        for (int i = 0; i < 2 * BYTES_PER_LINE + 8; i++) send_byte(8'($urandom), i == 0);
        wait_pixels_drained();
        idle_max = 11;
        apb_write(REG_MODE, 32'(1'b1));
        apb_write(REG_BASE, 32'($urandom_range(0, 16'hFFFF)));
        for (int i = 0; i < BYTES_PER_LINE; i++) send_byte(8'($urandom), 1'b0);
        wait_pixels_drained();
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        test_register_access();
        test_directed_patterns();
        test_random_traffic();
        test_line_boundaries();
        wait_pixels_drained();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
